### hw/rtl/rdc_pkg.sv
// Package: shared constants, types and helper functions of the radix digit converter.
package rdc_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int RADIX_W     = 7;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd72;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
  localparam logic [6:0]         CHAR_ZERO   = 7'd48;
  localparam logic [6:0]         CHAR_NINE   = 7'd57;
  localparam logic [6:0]         LETTER_GAP  = 7'd7;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Clamp the programmed radix into the supported range.
  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] v;
    v = r;
    if (v < RADIX_MIN) v = RADIX_MIN;
    if (v > RADIX_MAX) v = RADIX_MAX;
    return v;
  endfunction

  // Map a remainder to its ASCII code: digits, then letters and beyond.
  function automatic logic [6:0] digit_code(input logic [RADIX_W-1:0] rem);
    logic [6:0] d;
    d = rem + CHAR_ZERO;
    if (d > CHAR_NINE) d = d + LETTER_GAP;
    return d;
  endfunction

endpackage

### hw/rtl/rdc_stream_if.sv
// Interfaces: valid/ready channels for input values and output digit characters.
interface rdc_in_if;
  logic                            valid;
  logic                            ready;
  logic [rdc_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

### hw/rtl/radix_digit_converter.sv
// Top level: converts an integer into ASCII digits of a programmable radix, LSD first.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        value[VALUE_WIDTH-1:0]
//   out_chan  out  valid/ready        digit_char[6:0], last_digit
//   cfg       in   cfg_we (no wait)   cfg_wdata[6:0] = radix
//
// Each digit is computed in the bit-serial divider and then handed to the output
// register. Reset is synchronous, active low, and leaves radix 10 and an empty
// output. A stalled output holds the next digit in the divider; a new value is
// taken once the last digit of the run sits in the output register, even while
// that digit still waits.
module radix_digit_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  rdc_in_if.sink                      in_chan,
  rdc_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_wdata
);
  import rdc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             digit_r, digit_nxt;
  logic                   last_r, last_nxt;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]     div_rem;
  logic                   slot_free;

  rdc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (effective_radix(radix_r)),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // The output register can take a digit when empty or when it drains this cycle.
  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    div_start     = 1'b0;
    div_dividend  = div_quot;
    in_chan.ready = 1'b0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          // Start the first division straight from the accepted value.
          div_start    = 1'b1;
          div_dividend = in_chan.value;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && slot_free) begin
          out_valid_nxt = 1'b1;
          digit_nxt     = digit_code(div_rem);
          last_nxt      = (div_quot == '0);
          if (div_quot == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            // Advance to the next digit with the quotient as new dividend.
            div_start = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radix_r     <= RADIX_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) radix_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    last_r  <= last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit_char = digit_r;
  assign out_chan.last_digit = last_r;

endmodule

### hw/rtl/rdc_divider.sv
// Module: bit-serial restoring divider, one quotient bit per cycle.
module rdc_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]     divisor,
  output logic                            done,
  output logic [rdc_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [rdc_pkg::RADIX_W-1:0]     remainder
);
  import rdc_pkg::*;

  logic [VALUE_WIDTH-1:0] work_r, work_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     divisor_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, work_r[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor_r};
  assign diff  = trial - {1'b0, divisor_r};

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      work_nxt = {work_r[VALUE_WIDTH-2:0], ge};
      rem_nxt  = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (start) divisor_r <= divisor;
  end

  assign done      = done_r;
  assign quotient  = work_r;
  assign remainder = rem_r;

endmodule
